@@ rtl/bffa_pkg.sv @@
// shared types, constants and control bundles for the first-fit bitmap allocator
`timescale 1ns / 1ps
package bffa_pkg;

  localparam int BFFA_BLOCKS = 64;

  localparam int SIZE_W  = 8;
  localparam int START_W = 7;
  localparam int IDX_W   = 6;
  localparam int OCC_W   = 64;
  localparam int UNITS_W = 8;
  localparam int LEN_W   = 7;
  localparam int KSTEPS  = 7;
  localparam int K_W     = 3;

  localparam logic [SIZE_W-1:0] MAX_KB = 8'd128;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [SIZE_W-1:0]  size_kb;
    logic [START_W-1:0] start_block;
  } bffa_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] alloc_index;
    logic [OCC_W-1:0] occupancy;
  } bffa_rsp_t;

  typedef struct packed {
    logic           load;
    logic           step;
    logic [K_W-1:0] k;
    logic           pick;
    logic           alloc_commit;
    logic           free_commit;
    logic           set_status;
    logic [1:0]     status;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic bad_index;
    logic found;
  } bffa_sts_t;

endpackage

@@ rtl/bffa_datapath.sv @@
// occupancy map, run search by length doubling, priority pick and map update
`timescale 1ns / 1ps
module bffa_datapath #(
  parameter int BLOCKS = bffa_pkg::BFFA_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bffa_pkg::bffa_req_t req,
  input  bffa_pkg::bffa_cmd_t cmd,
  output bffa_pkg::bffa_sts_t sts,
  output bffa_pkg::bffa_rsp_t rsp
);
  import bffa_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam logic [BLOCKS-1:0] ALL_BLOCKS = {BLOCKS{1'b1}};

  logic [BLOCKS-1:0]  map_r, map_nxt;
  logic [BLOCKS-1:0]  acc_r, acc_nxt;
  logic [BLOCKS-1:0]  pow_r, pow_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [UNITS_W-1:0] units_r;
  logic [START_W-1:0] start_r;
  logic               is_free_r, too_large_r, bad_index_r;
  logic               found_r;
  logic [IW-1:0]      pick_idx_r;
  logic [IW-1:0]      index_r;
  logic [1:0]         status_r;

  logic [SIZE_W:0]    size_sum;
  logic [UNITS_W-1:0] units_in;
  logic [BLOCKS-1:0]  therm;
  logic [BLOCKS-1:0]  run_mask;
  logic [IW-1:0]      shift_amt;
  logic [IW-1:0]      enc_idx;
  logic               enc_any;
  logic [LEN_W-1:0]   pow_len;

  // units of 2 KB, rounded up
  always_comb begin
    size_sum = {1'b0, req.size_kb} + (SIZE_W+1)'(1);
    units_in = size_sum[SIZE_W:1];
    if (req.opcode == OP_ALLOC && units_in == '0) begin
      units_in = UNITS_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < BLOCKS; i++) begin
      therm[i] = (UNITS_W'(i) < units_r);
    end
  end

  assign shift_amt = cmd.free_commit ? start_r[IW-1:0] : pick_idx_r;
  assign run_mask  = therm << shift_amt;
  assign pow_len   = LEN_W'(1) << cmd.k;

  always_comb begin
    enc_idx = '0;
    enc_any = 1'b0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (acc_r[i]) begin
        enc_idx = IW'(i);
        enc_any = 1'b1;
      end
    end
  end

  always_comb begin
    map_nxt = map_r;
    acc_nxt = acc_r;
    pow_nxt = pow_r;
    len_nxt = len_r;
    if (cmd.load) begin
      acc_nxt = ALL_BLOCKS;
      pow_nxt = ~map_r;
      len_nxt = '0;
    end
    if (cmd.step) begin
      pow_nxt = pow_r & (pow_r >> pow_len);
      if (units_r[cmd.k]) begin
        acc_nxt = acc_r & (pow_r >> len_r);
        len_nxt = len_r + pow_len;
      end
    end
    if (cmd.free_commit) begin
      map_nxt = map_r & ~run_mask;
    end
    if (cmd.alloc_commit) begin
      map_nxt = map_r | run_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pow_r <= pow_nxt;
    len_r <= len_nxt;
    if (cmd.load) begin
      units_r     <= units_in;
      start_r     <= req.start_block;
      is_free_r   <= (req.opcode == OP_FREE);
      too_large_r <= (req.size_kb > MAX_KB);
      bad_index_r <= ({1'b0, req.start_block} >= (START_W+1)'(BLOCKS));
      index_r     <= '0;
    end
    if (cmd.pick) begin
      found_r    <= enc_any;
      pick_idx_r <= enc_idx;
    end
    if (cmd.alloc_commit) begin
      index_r <= pick_idx_r;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  assign sts.is_free   = is_free_r;
  assign sts.too_large = too_large_r;
  assign sts.bad_index = bad_index_r;
  assign sts.found     = found_r;

  assign rsp.status      = status_r;
  assign rsp.alloc_index = IDX_W'(index_r);
  assign rsp.occupancy   = OCC_W'(map_r);

endmodule

@@ rtl/bffa_ctrl.sv @@
// request sequencer: decode, search steps, pick, commit and result strobe
`timescale 1ns / 1ps
module bffa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bffa_pkg::bffa_sts_t sts,
  output logic                busy,
  output logic                out_valid,
  output bffa_pkg::bffa_cmd_t cmd
);
  import bffa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0]     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.k     = k_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_free) begin
          cmd.set_status = 1'b1;
          if (sts.bad_index) begin
            cmd.status = ST_BAD_INDEX;
          end else begin
            cmd.free_commit = 1'b1;
            cmd.status      = ST_OK;
          end
          state_nxt = S_REPORT;
        end else if (sts.too_large) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_TOO_LARGE;
          state_nxt      = S_REPORT;
        end else begin
          k_nxt     = '0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (k_r == K_W'(KSTEPS - 1)) begin
          state_nxt = S_PICK;
        end else begin
          k_nxt = k_r + K_W'(1);
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.set_status = 1'b1;
        if (sts.found) begin
          cmd.alloc_commit = 1'b1;
          cmd.status       = ST_OK;
        end else begin
          cmd.status = ST_NO_SPACE;
        end
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_REPORT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

@@ rtl/bitmap_first_fit_allocator.sv @@
// top level of the first-fit bitmap block allocator
//
//   channel  ports                     handshake
//   request  start, busy, in_req       beat taken when start & !busy
//   result   out_valid, out_rsp        one-cycle strobe, no back-pressure
//
// a free request, or an oversized allocate, goes from the check state straight to the result strobe
// an allocate passes a check, one search step per bit of the unit count (7),
// then a priority pick over the candidate starts, a commit to the map and the strobe
// busy stays high from the accepting edge until the result strobe has gone
// synchronous active-low reset empties the map; the receiver cannot stall
`timescale 1ns / 1ps
module bitmap_first_fit_allocator #(
  parameter int BLOCKS = bffa_pkg::BFFA_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bffa_pkg::bffa_req_t in_req,
  output logic                out_valid,
  output bffa_pkg::bffa_rsp_t out_rsp
);
  import bffa_pkg::*;

  bffa_cmd_t cmd;
  bffa_sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bffa_datapath #(
    .BLOCKS (BLOCKS)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .cmd   (cmd),
    .sts   (sts),
    .rsp   (out_rsp)
  );

endmodule

@@ tb/bffa_checker.sv @@
// checker for the first-fit bitmap allocator: predicts each result and compares it
`timescale 1ns / 1ps
module bffa_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bffa_pkg::bffa_req_t in_req,
  input  logic                out_valid,
  input  bffa_pkg::bffa_rsp_t out_rsp,
  output int unsigned         err_count,
  output int unsigned         pending
);
  import bffa_pkg::*;

  localparam int BLOCKS = BFFA_BLOCKS;

  logic [OCC_W-1:0] used_map;
  bffa_rsp_t        rsp_due[$];
  bffa_rsp_t        want;

  initial begin
    err_count = 0;
    pending   = 0;
    used_map  = '0;
  end

  function automatic logic [OCC_W-1:0] ones_below(input int unsigned n);
    if (n >= OCC_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // first-fit placement or release against the shadow map
  function automatic bffa_rsp_t place_or_release(input bffa_req_t r);
    bffa_rsp_t        rsp;
    int unsigned      units;
    int unsigned      pos;
    logic [OCC_W-1:0] run;
    logic             hit;
    rsp        = '0;
    rsp.status = ST_OK;
    units      = (int'(r.size_kb) + 1) / 2;
    hit        = 1'b0;
    if (r.opcode == OP_ALLOC) begin
      if (r.size_kb > MAX_KB) begin
        rsp.status = ST_TOO_LARGE;
      end else begin
        if (units == 0) units = 1;
        if (units <= BLOCKS) begin
          for (pos = 0; pos + units <= BLOCKS; pos++) begin
            run = ones_below(units) << pos;
            if (!hit && (used_map & run) == '0) begin
              used_map        = used_map | run;
              rsp.alloc_index = IDX_W'(pos);
              hit             = 1'b1;
            end
          end
        end
        if (!hit) rsp.status = ST_NO_SPACE;
      end
    end else if (r.start_block >= BLOCKS) begin
      rsp.status = ST_BAD_INDEX;
    end else begin
      used_map = used_map & ~((ones_below(units) << r.start_block) & ones_below(BLOCKS));
    end
    used_map      = used_map & ones_below(BLOCKS);
    rsp.occupancy = used_map;
    return rsp;
  endfunction

  task automatic flag(input string what, input logic [OCC_W-1:0] got,
                      input logic [OCC_W-1:0] exp_val);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, exp_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      used_map = '0;
      rsp_due.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (rsp_due.size() == 0) begin
          flag("unrequested result", out_rsp.occupancy, '0);
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp.status !== want.status)
            flag("status", out_rsp.status, want.status);
          if (out_rsp.alloc_index !== want.alloc_index)
            flag("alloc_index", out_rsp.alloc_index, want.alloc_index);
          if (out_rsp.occupancy !== want.occupancy)
            flag("occupancy", out_rsp.occupancy, want.occupancy);
        end
      end
      if (start && !busy) rsp_due.push_back(place_or_release(in_req));
    end
    pending = rsp_due.size();
  end

endmodule

@@ tb/tb_bitmap_first_fit_allocator.sv @@
// testbench top for the first-fit bitmap allocator: request stimulus and verdict
`timescale 1ns / 1ps
module tb_bitmap_first_fit_allocator;
  import bffa_pkg::*;

  localparam int RANDOM_BEATS = 1100;
  localparam int STALL_LIMIT  = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  bffa_req_t   in_req;
  logic        out_valid;
  bffa_rsp_t   out_rsp;
  int unsigned err_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;

  always #10 clk = ~clk;

  bitmap_first_fit_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  bffa_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .err_count (err_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic bffa_req_t mk_req(input logic op, input int unsigned size,
                                       input int unsigned first);
    bffa_req_t r;
    r.opcode      = op;
    r.size_kb     = SIZE_W'(size);
    r.start_block = START_W'(first);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(4, 1);
    return $urandom_range(40, 5);
  endfunction

  // mostly small allocations and frees so the map fragments and refills
  function automatic bffa_req_t random_req();
    int unsigned roll;
    int unsigned sz;
    roll = $urandom_range(99);
    if (roll < 55) begin
      roll = $urandom_range(99);
      if (roll < 70)      sz = $urandom_range(16, 0);
      else if (roll < 90) sz = $urandom_range(64, 17);
      else if (roll < 97) sz = $urandom_range(128, 65);
      else                sz = $urandom_range(255, 129);
      return mk_req(OP_ALLOC, sz, $urandom_range(127));
    end
    if (roll < 95) begin
      if ($urandom_range(99) < 3) return mk_req(OP_FREE, 255, 0);
      sz = ($urandom_range(9) < 8) ? $urandom_range(24, 0) : $urandom_range(255, 25);
      return mk_req(OP_FREE, sz, $urandom_range(63));
    end
    return mk_req(OP_FREE, $urandom_range(255), $urandom_range(127, 64));
  endfunction

  task automatic issue(input bffa_req_t r, input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  bffa_req_t   directed[$];
  logic        burst;
  int unsigned n;

  initial begin
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk_req(OP_ALLOC, 0, 0));
    directed.push_back(mk_req(OP_ALLOC, 1, 127));
    directed.push_back(mk_req(OP_ALLOC, 2, 0));
    directed.push_back(mk_req(OP_ALLOC, 3, 0));
    directed.push_back(mk_req(OP_ALLOC, 128, 0));
    directed.push_back(mk_req(OP_ALLOC, 129, 0));
    directed.push_back(mk_req(OP_ALLOC, 255, 127));
    directed.push_back(mk_req(OP_FREE, 4, 64));
    directed.push_back(mk_req(OP_FREE, 255, 127));
    directed.push_back(mk_req(OP_FREE, 0, 1));
    directed.push_back(mk_req(OP_FREE, 2, 1));
    directed.push_back(mk_req(OP_ALLOC, 4, 0));
    directed.push_back(mk_req(OP_ALLOC, 2, 0));
    directed.push_back(mk_req(OP_FREE, 8, 40));
    directed.push_back(mk_req(OP_FREE, 255, 0));
    directed.push_back(mk_req(OP_ALLOC, 128, 0));
    directed.push_back(mk_req(OP_ALLOC, 0, 0));
    directed.push_back(mk_req(OP_FREE, 255, 63));
    directed.push_back(mk_req(OP_ALLOC, 1, 0));
    directed.push_back(mk_req(OP_FREE, 63, 32));
    directed.push_back(mk_req(OP_ALLOC, 64, 0));
    directed.push_back(mk_req(OP_FREE, 127, 0));
    directed.push_back(mk_req(OP_ALLOC, 127, 0));
    directed.push_back(mk_req(OP_FREE, 170, 85));
    directed.push_back(mk_req(OP_FREE, 85, 42));

    foreach (directed[i]) issue(directed[i], pick_gap());
    drain();

    burst = 1'b0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(3) == 0);
      if (n == RANDOM_BEATS / 2) drain();
      issue(random_req(), burst ? 0 : pick_gap());
    end
    drain();
    repeat (30) @(negedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ bitmap_first_fit_allocator.f @@
rtl/bffa_pkg.sv
rtl/bffa_datapath.sv
rtl/bffa_ctrl.sv
rtl/bitmap_first_fit_allocator.sv
tb/bffa_checker.sv
tb/tb_bitmap_first_fit_allocator.sv
